[rtl/tscr_pkg.sv]
package tscr_pkg;

    localparam int MAX_SAMPLES  = 256;
    localparam int PAYLOAD_BITS = 64;
    localparam int ADDR_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int TIME_W       = 32;
    localparam int SPACING_W    = 20;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    // about 1/130 s
    localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(7692);

    typedef enum logic [2:0] {
        KIND_RESET         = 3'd0,
        KIND_BEGIN_CAPTURE = 3'd1,
        KIND_CAPTURE_TICK  = 3'd2,
        KIND_BEGIN_REPLAY  = 3'd3,
        KIND_REPLAY_TICK   = 3'd4,
        KIND_FIND          = 3'd5
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPTURE_TARGET = 2'd0,
        CFG_REPLAY_SKIP    = 2'd1,
        CFG_MIN_SPACING    = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_FETCH,
        S_SDATA,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                    wr_en;
        logic [ADDR_W-1:0]       wr_addr;
        logic [TIME_W-1:0]       wr_time;
        logic [PAYLOAD_BITS-1:0] wr_sample;
        logic                    time_rd_en;
        logic [ADDR_W-1:0]       time_rd_addr;
        logic                    samp_rd_en;
        logic [ADDR_W-1:0]       samp_rd_addr;
    } t_store_req;

endpackage

[rtl/tscr_store.sv]
module tscr_store (
    input  logic                              i_clk,
    input  tscr_pkg::t_store_req              i_req,
    output logic [tscr_pkg::TIME_W-1:0]       o_time_q,
    output logic [tscr_pkg::PAYLOAD_BITS-1:0] o_samp_q
);

    logic [tscr_pkg::TIME_W-1:0]       time_mem [tscr_pkg::MAX_SAMPLES];
    logic [tscr_pkg::PAYLOAD_BITS-1:0] samp_mem [tscr_pkg::MAX_SAMPLES];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            time_mem[i_req.wr_addr] <= i_req.wr_time;
        end
        if (i_req.time_rd_en) begin
            o_time_q <= time_mem[i_req.time_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            samp_mem[i_req.wr_addr] <= i_req.wr_sample;
        end
        if (i_req.samp_rd_en) begin
            o_samp_q <= samp_mem[i_req.samp_rd_addr];
        end
    end

endmodule

[rtl/timed_sample_capture_replay_core.sv]
// channel   direction  handshake                   payload
// input     in         i_valid / o_stall           i_kind i_now_us i_payload i_query_time
// result    out        o_valid / i_stall           o_payload_out o_found_index o_found
//                                                  o_capture_done o_replaying o_replay_done
//                                                  o_sample_count
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index i_cfg_data
//
// one item at a time; reset, capture and begin replay events pass through the EXEC
// and DONE states into the result register
// find and replay tick scan the time memory at one entry per cycle; a replay tick
// past the last sample fetches the last sample without a scan
// the result register lets the next item transfer in while a result is stalled
// synchronous active-low reset clears control state; the sample memories need no clearing
module timed_sample_capture_replay_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [2:0]                            i_kind,
    input  logic [tscr_pkg::TIME_W-1:0]           i_now_us,
    input  logic [63:0]                           i_payload,
    input  logic [tscr_pkg::TIME_W-1:0]           i_query_time,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [63:0]                           o_payload_out,
    output logic [tscr_pkg::ADDR_W-1:0]           o_found_index,
    output logic                                  o_found,
    output logic                                  o_capture_done,
    output logic                                  o_replaying,
    output logic                                  o_replay_done,
    output logic [tscr_pkg::CNT_W-1:0]            o_sample_count,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tscr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tscr_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int TW = tscr_pkg::TIME_W;
    localparam int PB = tscr_pkg::PAYLOAD_BITS;
    localparam int AW = tscr_pkg::ADDR_W;
    localparam int CW = tscr_pkg::CNT_W;

    // configuration
    logic [TW-1:0]                  r_capture_target;
    logic [TW-1:0]                  r_replay_skip;
    logic [tscr_pkg::SPACING_W-1:0] r_min_spacing;

    // control and block state
    tscr_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic [PB-1:0]    r_frozen, n_frozen;
    logic             r_has_snap, n_has_snap;
    logic [CW-1:0]    r_count, n_count;
    logic             r_cap_fin, n_cap_fin;
    logic [TW-1:0]    r_cap_start, n_cap_start;
    logic [TW-1:0]    r_rep_start, n_rep_start;
    logic             r_rep_active, n_rep_active;
    logic             r_rep_fin, n_rep_fin;
    logic [TW-1:0]    r_last_time, n_last_time;

    // item and work registers
    tscr_pkg::t_kind  r_kind, n_kind;
    logic [TW-1:0]    r_now, n_now;
    logic [63:0]      r_pay, n_pay;
    logic [TW-1:0]    r_query, n_query;
    logic [CW-1:0]    r_addr, n_addr;
    logic             r_pend, n_pend;
    logic [AW-1:0]    r_pend_idx, n_pend_idx;
    logic [TW-1:0]    r_key, n_key;
    logic             r_is_replay, n_is_replay;
    logic [AW-1:0]    r_fidx, n_fidx;
    logic             r_end_replay, n_end_replay;
    logic [63:0]      r_res_pay, n_res_pay;
    logic [AW-1:0]    r_res_fidx, n_res_fidx;
    logic             r_res_found, n_res_found;

    // result register
    logic [63:0]      r_o_pay, n_o_pay;
    logic [AW-1:0]    r_o_fidx, n_o_fidx;
    logic             r_o_found, n_o_found;
    logic             r_o_cap_done, n_o_cap_done;
    logic             r_o_replaying, n_o_replaying;
    logic             r_o_rep_done, n_o_rep_done;
    logic [CW-1:0]    r_o_count, n_o_count;

    tscr_pkg::t_store_req s_req;
    logic [TW-1:0]        time_q;
    logic [PB-1:0]        samp_q;

    logic [TW-1:0] el;
    logic [TW-1:0] el_gap;
    logic          spaced;
    logic [TW-1:0] rep_t;
    logic [AW-1:0] last_idx;
    logic          out_free;

    tscr_store u_store (
        .i_clk    (i_clk),
        .i_req    (s_req),
        .o_time_q (time_q),
        .o_samp_q (samp_q)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture_target <= '0;
            r_replay_skip    <= '0;
            r_min_spacing    <= tscr_pkg::SPACING_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (tscr_pkg::t_cfg_idx'(i_cfg_index))
                tscr_pkg::CFG_CAPTURE_TARGET: r_capture_target <= i_cfg_data[TW-1:0];
                tscr_pkg::CFG_REPLAY_SKIP:    r_replay_skip    <= i_cfg_data[TW-1:0];
                tscr_pkg::CFG_MIN_SPACING:
                    r_min_spacing <= i_cfg_data[tscr_pkg::SPACING_W-1:0];
                default: ;
            endcase
        end
    end

    assign el       = r_now - r_cap_start;
    assign el_gap   = el - r_last_time;
    assign spaced   = (el >= r_last_time) && (el_gap >= TW'(r_min_spacing));
    assign rep_t    = r_now - r_rep_start;
    assign last_idx = AW'(r_count - CW'(1));
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != tscr_pkg::S_IDLE);

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && i_stall;
        n_frozen      = r_frozen;
        n_has_snap    = r_has_snap;
        n_count       = r_count;
        n_cap_fin     = r_cap_fin;
        n_cap_start   = r_cap_start;
        n_rep_start   = r_rep_start;
        n_rep_active  = r_rep_active;
        n_rep_fin     = r_rep_fin;
        n_last_time   = r_last_time;
        n_kind        = r_kind;
        n_now         = r_now;
        n_pay         = r_pay;
        n_query       = r_query;
        n_addr        = r_addr;
        n_pend        = r_pend;
        n_pend_idx    = r_pend_idx;
        n_key         = r_key;
        n_is_replay   = r_is_replay;
        n_fidx        = r_fidx;
        n_end_replay  = r_end_replay;
        n_res_pay     = r_res_pay;
        n_res_fidx    = r_res_fidx;
        n_res_found   = r_res_found;
        n_o_pay       = r_o_pay;
        n_o_fidx      = r_o_fidx;
        n_o_found     = r_o_found;
        n_o_cap_done  = r_o_cap_done;
        n_o_replaying = r_o_replaying;
        n_o_rep_done  = r_o_rep_done;
        n_o_count     = r_o_count;
        s_req         = '0;

        case (r_state)
            tscr_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_kind  = tscr_pkg::t_kind'(i_kind);
                    n_now   = i_now_us;
                    n_pay   = i_payload;
                    n_query = i_query_time;
                    n_state = tscr_pkg::S_EXEC;
                end
            end
            tscr_pkg::S_EXEC: begin
                n_state     = tscr_pkg::S_DONE;
                n_res_pay   = r_pay;
                n_res_fidx  = '0;
                n_res_found = 1'b0;
                case (r_kind)
                    tscr_pkg::KIND_RESET: begin
                        n_frozen     = '0;
                        n_has_snap   = 1'b0;
                        n_count      = '0;
                        n_cap_fin    = 1'b0;
                        n_cap_start  = '0;
                        n_rep_start  = '0;
                        n_rep_active = 1'b0;
                        n_rep_fin    = 1'b0;
                        n_last_time  = '0;
                    end
                    tscr_pkg::KIND_BEGIN_CAPTURE: begin
                        n_frozen        = r_pay[PB-1:0];
                        n_has_snap      = 1'b1;
                        s_req.wr_en     = 1'b1;
                        s_req.wr_addr   = '0;
                        s_req.wr_time   = '0;
                        s_req.wr_sample = r_pay[PB-1:0];
                        n_count         = CW'(1);
                        n_cap_fin       = 1'b0;
                        n_cap_start     = r_now;
                        n_last_time     = '0;
                    end
                    tscr_pkg::KIND_CAPTURE_TICK: begin
                        if (r_has_snap) begin
                            if (!r_cap_fin) begin
                                if (r_count >= CW'(tscr_pkg::MAX_SAMPLES)
                                        || el >= r_capture_target) begin
                                    n_cap_fin = 1'b1;
                                end else if (spaced) begin
                                    s_req.wr_en     = 1'b1;
                                    s_req.wr_addr   = r_count[AW-1:0];
                                    s_req.wr_time   = el;
                                    s_req.wr_sample = r_pay[PB-1:0];
                                    n_count         = r_count + CW'(1);
                                    n_last_time     = el;
                                end
                            end
                            n_res_pay = 64'(r_frozen);
                        end
                    end
                    tscr_pkg::KIND_BEGIN_REPLAY: begin
                        n_rep_start  = r_now - r_replay_skip;
                        n_rep_active = (r_count > CW'(1)) && (r_replay_skip < r_last_time);
                        n_rep_fin    = (r_count > CW'(1)) && (r_replay_skip >= r_last_time);
                    end
                    tscr_pkg::KIND_REPLAY_TICK: begin
                        if (r_rep_active && (r_count != '0)) begin
                            if (rep_t >= r_last_time) begin
                                n_fidx       = last_idx;
                                n_end_replay = 1'b1;
                                n_state      = tscr_pkg::S_FETCH;
                            end else begin
                                n_key        = rep_t;
                                n_addr       = CW'(1);
                                n_pend       = 1'b0;
                                n_is_replay  = 1'b1;
                                n_end_replay = 1'b0;
                                n_state      = tscr_pkg::S_SEARCH;
                            end
                        end
                    end
                    tscr_pkg::KIND_FIND: begin
                        n_key       = r_query;
                        n_addr      = '0;
                        n_pend      = 1'b0;
                        n_is_replay = 1'b0;
                        n_state     = tscr_pkg::S_SEARCH;
                    end
                    default: ;
                endcase
            end
            tscr_pkg::S_SEARCH: begin
                if (r_pend && (time_q >= r_key)) begin
                    n_pend = 1'b0;
                    if (r_is_replay) begin
                        n_fidx  = r_pend_idx;
                        n_state = tscr_pkg::S_FETCH;
                    end else begin
                        n_res_fidx  = r_pend_idx;
                        n_res_found = 1'b1;
                        n_state     = tscr_pkg::S_DONE;
                    end
                end else if (r_addr < r_count) begin
                    s_req.time_rd_en   = 1'b1;
                    s_req.time_rd_addr = r_addr[AW-1:0];
                    n_pend             = 1'b1;
                    n_pend_idx         = r_addr[AW-1:0];
                    n_addr             = r_addr + CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (r_is_replay) begin
                        n_fidx  = last_idx;
                        n_state = tscr_pkg::S_FETCH;
                    end else begin
                        n_state = tscr_pkg::S_DONE;
                    end
                end
            end
            tscr_pkg::S_FETCH: begin
                s_req.samp_rd_en   = 1'b1;
                s_req.samp_rd_addr = r_fidx;
                n_state            = tscr_pkg::S_SDATA;
            end
            tscr_pkg::S_SDATA: begin
                n_res_pay = 64'(samp_q);
                if (r_end_replay) begin
                    n_rep_active = 1'b0;
                    n_rep_fin    = 1'b1;
                end
                n_state = tscr_pkg::S_DONE;
            end
            tscr_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_o_pay       = r_res_pay;
                    n_o_fidx      = r_res_fidx;
                    n_o_found     = r_res_found;
                    n_o_cap_done  = r_cap_fin;
                    n_o_replaying = r_rep_active;
                    n_o_rep_done  = r_rep_fin;
                    n_o_count     = r_count;
                    n_state       = tscr_pkg::S_IDLE;
                end
            end
            default: n_state = tscr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tscr_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_frozen     <= '0;
            r_has_snap   <= 1'b0;
            r_count      <= '0;
            r_cap_fin    <= 1'b0;
            r_cap_start  <= '0;
            r_rep_start  <= '0;
            r_rep_active <= 1'b0;
            r_rep_fin    <= 1'b0;
            r_last_time  <= '0;
            r_pend       <= 1'b0;
            r_addr       <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_frozen     <= n_frozen;
            r_has_snap   <= n_has_snap;
            r_count      <= n_count;
            r_cap_fin    <= n_cap_fin;
            r_cap_start  <= n_cap_start;
            r_rep_start  <= n_rep_start;
            r_rep_active <= n_rep_active;
            r_rep_fin    <= n_rep_fin;
            r_last_time  <= n_last_time;
            r_pend       <= n_pend;
            r_addr       <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind        <= n_kind;
        r_now         <= n_now;
        r_pay         <= n_pay;
        r_query       <= n_query;
        r_pend_idx    <= n_pend_idx;
        r_key         <= n_key;
        r_is_replay   <= n_is_replay;
        r_fidx        <= n_fidx;
        r_end_replay  <= n_end_replay;
        r_res_pay     <= n_res_pay;
        r_res_fidx    <= n_res_fidx;
        r_res_found   <= n_res_found;
        r_o_pay       <= n_o_pay;
        r_o_fidx      <= n_o_fidx;
        r_o_found     <= n_o_found;
        r_o_cap_done  <= n_o_cap_done;
        r_o_replaying <= n_o_replaying;
        r_o_rep_done  <= n_o_rep_done;
        r_o_count     <= n_o_count;
    end

    assign o_valid        = r_out_valid;
    assign o_payload_out  = r_o_pay;
    assign o_found_index  = r_o_fidx;
    assign o_found        = r_o_found;
    assign o_capture_done = r_o_cap_done;
    assign o_replaying    = r_o_replaying;
    assign o_replay_done  = r_o_rep_done;
    assign o_sample_count = r_o_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(tscr_pkg::MAX_SAMPLES))
        else $error("sample count above store depth");

    a_replay_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_rep_active && r_rep_fin))
        else $error("replay active and finished together");

    a_fin_needs_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cap_fin |-> r_has_snap)
        else $error("capture finished without a snapshot");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tscr_pkg::S_SEARCH) |-> (r_addr <= r_count))
        else $error("scan address past stored samples");

    a_write_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_req.wr_en |-> (r_state == tscr_pkg::S_EXEC))
        else $error("store write outside event execution");

endmodule
